// ===== sv/dmsd_pkg.sv =====
// shared types and constants for the dual mode stream deframer
`default_nettype none

package dmsd_pkg;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_PAYLOAD   = 3'd1,
    KIND_TEXT      = 3'd2,
    KIND_TEXT_END  = 3'd3,
    KIND_BAD_MAGIC = 3'd4,
    KIND_SHORT     = 3'd5
  } kind_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [7:0]         data;
    logic signed [31:0] dest;
    logic [31:0]        plen;
    logic               last;
  } result_t;

  localparam logic [7:0] NUL_BYTE = 8'h00;
  localparam logic [3:0] MAGIC_BYTES = 4'd4;
  localparam logic [3:0] LENGTH_END = 4'd8;
  localparam logic [3:0] HEADER_BYTES = 4'd12;
  localparam logic [31:0] BODY_PREFIX = 32'd4;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = 8'h4F;
      2'd1: b = 8'h4E;
      2'd2: b = 8'h43;
      2'd3: b = 8'h31;
      default: b = 8'h4F;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== sv/dmsd_parser.sv =====
// parse state and per-beat result logic of the deframer
`default_nettype none

module dmsd_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              chunk_end,
  output dmsd_pkg::result_t      res
);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_HEADER  = 3'd1,
    MODE_PAYLOAD = 3'd2,
    MODE_TEXT    = 3'd3,
    MODE_DROP    = 3'd4
  } mode_t;

  mode_t       mode, mode_next;
  logic [3:0]  header_count, header_count_next;
  logic        magic_mismatch, magic_mismatch_next;
  logic [31:0] body_length, body_length_next;
  logic [31:0] dest_shift, dest_shift_next;
  logic [31:0] payload_remaining, payload_remaining_next;

  logic [3:0]  cnt_inc;
  logic        mism_upd;
  logic [31:0] blen_upd;
  logic [31:0] dest_upd;
  logic [31:0] plen;
  logic        fin;

  always_comb begin
    cnt_inc  = header_count + 4'd1;
    mism_upd = magic_mismatch |
               ((header_count < dmsd_pkg::MAGIC_BYTES) &&
                (rx_byte != dmsd_pkg::magic_byte(header_count[1:0])));
    blen_upd = body_length;
    dest_upd = dest_shift;
    if (header_count >= dmsd_pkg::MAGIC_BYTES && header_count < dmsd_pkg::LENGTH_END) begin
      blen_upd = {body_length[23:0], rx_byte};
    end
    if (header_count >= dmsd_pkg::LENGTH_END) begin
      dest_upd = {dest_shift[23:0], rx_byte};
    end
    plen = blen_upd - dmsd_pkg::BODY_PREFIX;
    fin  = (payload_remaining <= 32'd1);
  end

  always_comb begin
    mode_next              = mode;
    header_count_next      = header_count;
    magic_mismatch_next    = magic_mismatch;
    body_length_next       = body_length;
    dest_shift_next        = dest_shift;
    payload_remaining_next = payload_remaining;
    res                    = '0;
    res.kind               = dmsd_pkg::KIND_HEADER;
    case (mode)
      MODE_HEADER: begin
        header_count_next   = cnt_inc;
        magic_mismatch_next = mism_upd;
        body_length_next    = blen_upd;
        dest_shift_next     = dest_upd;
        if (cnt_inc == dmsd_pkg::MAGIC_BYTES && mism_upd) begin
          mode_next           = chunk_end ? MODE_IDLE : MODE_DROP;
          header_count_next   = '0;
          magic_mismatch_next = 1'b0;
          body_length_next    = '0;
          dest_shift_next     = '0;
          res.valid           = 1'b1;
          res.kind            = dmsd_pkg::KIND_BAD_MAGIC;
        end else if (cnt_inc == dmsd_pkg::HEADER_BYTES) begin
          header_count_next   = '0;
          magic_mismatch_next = 1'b0;
          body_length_next    = '0;
          dest_shift_next     = '0;
          res.valid           = 1'b1;
          if (blen_upd < dmsd_pkg::BODY_PREFIX) begin
            mode_next = chunk_end ? MODE_IDLE : MODE_DROP;
            res.kind  = dmsd_pkg::KIND_SHORT;
          end else begin
            mode_next              = (plen == '0) ? MODE_IDLE : MODE_PAYLOAD;
            payload_remaining_next = plen;
            res.kind               = dmsd_pkg::KIND_HEADER;
            res.dest               = dest_upd;
            res.plen               = plen;
            res.last               = (plen == '0);
          end
        end
      end
      MODE_PAYLOAD: begin
        if (payload_remaining != '0) begin
          payload_remaining_next = payload_remaining - 32'd1;
        end
        if (fin) begin
          mode_next = MODE_IDLE;
        end
        res.valid = 1'b1;
        res.kind  = dmsd_pkg::KIND_PAYLOAD;
        res.data  = rx_byte;
        res.last  = fin;
      end
      MODE_TEXT: begin
        res.valid = 1'b1;
        if (rx_byte == dmsd_pkg::NUL_BYTE) begin
          mode_next = MODE_IDLE;
          res.kind  = dmsd_pkg::KIND_TEXT_END;
        end else begin
          res.kind = dmsd_pkg::KIND_TEXT;
          res.data = rx_byte;
        end
      end
      MODE_DROP: begin
        if (chunk_end) begin
          mode_next = MODE_IDLE;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
        if (rx_byte == dmsd_pkg::magic_byte(2'd0)) begin
          mode_next              = MODE_HEADER;
          header_count_next      = 4'd1;
          magic_mismatch_next    = 1'b0;
          body_length_next       = '0;
          dest_shift_next        = '0;
          payload_remaining_next = '0;
        end else if (rx_byte != dmsd_pkg::NUL_BYTE) begin
          mode_next = MODE_TEXT;
          res.valid = 1'b1;
          res.kind  = dmsd_pkg::KIND_TEXT;
          res.data  = rx_byte;
        end
      end
    endcase
    if (!step) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_IDLE;
      header_count      <= '0;
      magic_mismatch    <= 1'b0;
      body_length       <= '0;
      dest_shift        <= '0;
      payload_remaining <= '0;
    end else if (step) begin
      mode              <= mode_next;
      header_count      <= header_count_next;
      magic_mismatch    <= magic_mismatch_next;
      body_length       <= body_length_next;
      dest_shift        <= dest_shift_next;
      payload_remaining <= payload_remaining_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dual_mode_stream_deframer.sv =====
// top level of the dual mode stream deframer
// usage:
//   input channel in_valid/in_ready carries one beat per received byte, rx_byte plus
//   chunk_end, which marks the last byte of a receive chunk
//   output channel out_valid/out_ready carries at most one result beat per input beat:
//   frame header, payload byte, text byte, text end, bad magic or body too short
//   a beat is taken into an input register, then the parser state and the result
//   register update together when the beat advances out of the input register;
//   beats that give no result (header bytes, dropped bytes) vanish there
//   throughput is one beat per cycle while the receiver keeps out_ready high
//   when the receiver stalls, the result register holds its beat and the input
//   register fills, after which in_ready drops until out_ready returns
//   synchronous reset returns the parser to idle, empties both registers and
//   discards any partial frame or text message
`default_nettype none

module dual_mode_stream_deframer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               chunk_end,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              result_kind,
  output logic [7:0]              out_byte,
  output logic signed [31:0]      dest_user,
  output logic [31:0]             payload_length,
  output logic                    last
);

  logic              in_full;
  logic [7:0]        in_byte;
  logic              in_end;
  logic              advance;
  dmsd_pkg::result_t res;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  dmsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .rx_byte   (in_byte),
    .chunk_end (in_end),
    .res       (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
      in_end  <= chunk_end;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= res.valid;
    end
    if (res.valid && (!out_valid || out_ready)) begin
      result_kind    <= res.kind;
      out_byte       <= res.data;
      dest_user      <= res.dest;
      payload_length <= res.plen;
      last           <= res.last;
    end
  end

  a_header_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == dmsd_pkg::KIND_HEADER |-> last == (payload_length == '0))
    else $error("header last flag does not match empty payload");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != dmsd_pkg::KIND_PAYLOAD && result_kind != dmsd_pkg::KIND_TEXT
    |-> out_byte == '0)
    else $error("byte field set on a result without a byte");

  a_header_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != dmsd_pkg::KIND_HEADER |-> dest_user == '0 && payload_length == '0)
    else $error("header fields set on a non-header result");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_kind <= dmsd_pkg::KIND_SHORT)
    else $error("result kind out of range");

  a_stall_fill: assert property (@(posedge clk) disable iff (rst)
    !in_full |-> in_ready)
    else $error("input register empty but not ready");

endmodule

`default_nettype wire
